// ===== rtl/core/sidta_pkg.sv =====
// ----------------------------------------------------------------------------
// sidta_pkg
// Shared constants, queue entry type and conversion helpers for the signed
// integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sidta_pkg;

    localparam int WORD_BITS     = 32;
    // decimal digits of 2^(WORD_BITS-1); log10(2) ~ 0.30103
    localparam int DIGITS        = ((WORD_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_BITS      = DIGITS * 4;
    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = (WORD_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int MAG_BITS      = STEPS * BITS_PER_STEP;
    localparam int STEP_W        = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int IDX_W         = $clog2(DIGITS);

    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    typedef struct packed {
        logic                neg;
        logic [BCD_BITS-1:0] bcd;
        logic [IDX_W-1:0]    top;   // index of most significant digit to print
    } entry_t;

    // one double-dabble bit: add 3 to every digit of five or more, then shift in
    function automatic logic [BCD_BITS-1:0] dabble_step(
        input logic [BCD_BITS-1:0] bcd,
        input logic                bit_in
    );
        logic [BCD_BITS-1:0] adj;
        logic [3:0]          dig;
        int                  d;
        adj = bcd;
        for (d = 0; d < DIGITS; d++)
        begin
            dig = bcd[d*4 +: 4];
            if (dig >= 4'd5)
            begin
                adj[d*4 +: 4] = dig + 4'd3;
            end
        end
        return {adj[BCD_BITS-2:0], bit_in};
    endfunction

    // highest non-zero digit; zero itself prints one digit
    function automatic logic [IDX_W-1:0] top_index(input logic [BCD_BITS-1:0] bcd);
        logic [IDX_W-1:0] top;
        int               d;
        top = '0;
        for (d = 0; d < DIGITS; d++)
        begin
            if (bcd[d*4 +: 4] != 4'd0)
            begin
                top = IDX_W'(d);
            end
        end
        return top;
    endfunction

endpackage

// ===== rtl/core/sidta_front.sv =====
// ----------------------------------------------------------------------------
// sidta_front
// Accepts an item, splits off the sign and converts the magnitude to BCD,
// four bits a cycle, then hands the result to the queue.
// ----------------------------------------------------------------------------
module sidta_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [sidta_pkg::WORD_BITS-1:0] value,
    input  logic                                   value_valid,
    output logic                                   value_ready,
    output sidta_pkg::entry_t                      entry,
    output logic                                   entry_valid,
    input  logic                                   entry_ready
);
    import sidta_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                neg_reg, neg_next;
    logic [MAG_BITS-1:0] mag_reg, mag_next;
    logic [BCD_BITS-1:0] bcd_reg, bcd_next;

    logic [WORD_BITS-1:0] raw;
    logic [WORD_BITS-1:0] mag_abs;
    logic [MAG_BITS-1:0]  mag_w;
    logic [BCD_BITS-1:0]  bcd_w;

    assign raw     = WORD_BITS'(value);
    // two's complement negate as unsigned: the most negative value stays exact
    assign mag_abs = raw[WORD_BITS-1] ? (~raw + 1'b1) : raw;

    always_comb
    begin
        mag_w = mag_reg;
        bcd_w = bcd_reg;
        for (int b = 0; b < BITS_PER_STEP; b++)
        begin
            bcd_w = dabble_step(bcd_w, mag_w[MAG_BITS-1]);
            mag_w = mag_w << 1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (value_valid)
                begin
                    neg_next   = raw[WORD_BITS-1];
                    mag_next   = MAG_BITS'(mag_abs);
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                mag_next  = mag_w;
                bcd_next  = bcd_w;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (entry_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign value_ready = (state_reg == ST_IDLE);
    assign entry_valid = (state_reg == ST_PUSH);
    assign entry.neg   = neg_reg;
    assign entry.bcd   = bcd_reg;
    assign entry.top   = top_index(bcd_reg);

endmodule

// ===== rtl/core/sidta_queue.sv =====
// ----------------------------------------------------------------------------
// sidta_queue
// Two-entry queue between the converter and the character emitter.
// ----------------------------------------------------------------------------
module sidta_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  sidta_pkg::entry_t push_entry,
    input  logic              push_valid,
    output logic              push_ready,
    output sidta_pkg::entry_t pop_entry,
    output logic              pop_valid,
    input  logic              pop_ready
);
    import sidta_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/sidta_back.sv =====
// ----------------------------------------------------------------------------
// sidta_back
// Emits the sign and the digits of one queued number, one character a cycle
// while the receiver is ready, most significant first, and flags the final one.
// ----------------------------------------------------------------------------
module sidta_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sidta_pkg::entry_t entry,
    input  logic              entry_valid,
    output logic              entry_ready,
    output logic [5:0]        character,
    output logic              last,
    output logic              text_valid,
    input  logic              text_ready
);
    import sidta_pkg::*;

    logic                busy_reg, busy_next;
    logic                neg_reg, neg_next;
    logic [BCD_BITS-1:0] bcd_reg, bcd_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    logic       taken;
    logic       final_char;
    logic       load;
    logic [3:0] digit;

    assign digit      = bcd_reg[{idx_reg, 2'b00} +: 4];
    assign final_char = !neg_reg && (idx_reg == '0);
    assign taken      = busy_reg && text_ready;
    // refill in the same cycle the final character goes, so items run back to back
    assign load       = entry_valid && (!busy_reg || (taken && final_char));

    assign entry_ready = load;
    assign text_valid  = busy_reg;
    assign last        = final_char;
    assign character   = neg_reg ? CHAR_MINUS : (CHAR_ZERO + {2'b00, digit});

    always_comb
    begin
        busy_next = busy_reg;
        neg_next  = neg_reg;
        bcd_next  = bcd_reg;
        idx_next  = idx_reg;
        if (taken)
        begin
            priority if (neg_reg)
            begin
                neg_next = 1'b0;
            end
            else if (idx_reg != '0)
            begin
                idx_next = idx_reg - 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            neg_next  = entry.neg;
            bcd_next  = entry.bcd;
            idx_next  = entry.top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            neg_reg  <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            neg_reg  <= neg_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
    end

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character per output item.
// ----------------------------------------------------------------------------
// Input channel: value with value_valid / value_ready. Output channel:
// character and last with text_valid / text_ready. Each number comes out as
// an optional '-' and then its digits, most significant first, without
// leading zeros; zero gives a single '0'. last marks the final character.
// The converter takes the item, runs a BCD shift-add over the magnitude
// four bits a cycle, and passes the result through a two-entry queue to
// the emitter. The converter takes no new item until it has handed the
// last one on; the emitter sends one character a cycle while the receiver
// is ready, 1 to 11 per number, and the slower of the two sets the pace.
// When the receiver stalls the character holds; the queue fills to two
// numbers, the converter finishes a third and holds it, and value_ready
// then stays low until the queue takes it.
// Reset clears all control state; nothing is kept between items.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [sidta_pkg::WORD_BITS-1:0] value,
    input  logic                                   value_valid,
    output logic                                   value_ready,
    output logic [5:0]                             character,
    output logic                                   last,
    output logic                                   text_valid,
    input  logic                                   text_ready
);
    import sidta_pkg::*;

    entry_t fe_entry, q_entry;
    logic   fe_valid, fe_ready;
    logic   q_valid, q_ready;

    sidta_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .entry       (fe_entry),
        .entry_valid (fe_valid),
        .entry_ready (fe_ready)
    );

    sidta_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (fe_entry),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .pop_entry  (q_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    sidta_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (q_entry),
        .entry_valid (q_valid),
        .entry_ready (q_ready),
        .character   (character),
        .last        (last),
        .text_valid  (text_valid),
        .text_ready  (text_ready)
    );

`ifndef SYNTHESIS
    // converter never offers a result while it is open for a new item
    a_front_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(value_ready && fe_valid))
        else $error("front ready while holding a result");

    // a number's text does not break off before its last character
    a_text_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && text_ready && !last) |=> text_valid)
        else $error("text ended without last");

    // the minus sign is followed by a digit
    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && text_ready && character == CHAR_MINUS) |=>
        (character != CHAR_MINUS))
        else $error("minus sign not followed by a digit");

    // the sign never carries the last flag
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && character == CHAR_MINUS) |-> !last)
        else $error("minus sign flagged last");
`endif

endmodule
